@@ rtl/rvb_pkg.sv @@
`default_nettype none

package rvb_pkg;

    localparam int WIN_MAX_DEF = 1024;
    localparam int MIN_WIN     = 30;
    localparam int FRAC_BITS   = 24;

    localparam int CFG_WIN_W   = 11;
    localparam int CFG_MULT_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_WIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_WIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 2'd3;

    localparam int PRICE_W  = 32;
    localparam int STAMP_W  = 48;
    localparam int SQ_VAL_W = 48;
    localparam int LG_INT_W = 6;
    localparam int LG_W     = LG_INT_W + FRAC_BITS;
    localparam int K_W      = 14;

    // serial multiplier: MUL_W x MUL_W, MUL_DIGIT bits of b per cycle
    localparam int MUL_DIGIT = 4;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;

    // serial divider: one quotient bit per cycle
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 33;

    // serial square root: one root bit per cycle
    localparam int SQRT_W = 64;

    localparam logic [1:0] SIG_NONE  = 2'b00;
    localparam logic [1:0] SIG_BELOW = 2'b01;
    localparam logic [1:0] SIG_ABOVE = 2'b11;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CONV,
        S_CONV_W,
        S_PWIN,
        S_MEAN,
        S_MEAN_W,
        S_SQ,
        S_SQ_W,
        S_DWIN,
        S_MS,
        S_MS_W,
        S_RMS_W,
        S_LG_NORM,
        S_LG_SQ,
        S_LG_SQW,
        S_LG_END,
        S_EMUL,
        S_EMUL_W,
        S_EXP,
        S_EXP_W,
        S_HI,
        S_HI_W,
        S_LO,
        S_LO_W,
        S_OUT
    } t_state;

    typedef logic [FRAC_BITS:1][31:0] t_coef_tab;

    // elaboration only: integer square root
    function automatic logic [63:0] isqrt_const(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = v;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // c_i = 2^(2^-i) in Q1.31, each the floored root of the previous
    function automatic t_coef_tab exp_coef_table();
        t_coef_tab   tab;
        logic [63:0] c;
        c = 64'h1_0000_0000;
        for (int i = 1; i <= FRAC_BITS; i++) begin
            c      = isqrt_const(c << 31);
            tab[i] = c[31:0];
        end
        return tab;
    endfunction

    localparam t_coef_tab EXP_COEF = exp_coef_table();

endpackage

`default_nettype wire

@@ rtl/rvb_ram.sv @@
`default_nettype none

module rvb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/rvb_mul.sv @@
`default_nettype none

module rvb_mul (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [rvb_pkg::MUL_W-1:0] i_a,
    input  wire logic [rvb_pkg::MUL_W-1:0] i_b,
    output logic                           o_done,
    output logic [rvb_pkg::PROD_W-1:0]     o_prod
);

    import rvb_pkg::*;

    localparam int NDIG  = (MUL_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BS_W  = NDIG * MUL_DIGIT;
    localparam int CNT_W = $clog2(NDIG + 1);
    localparam int PP_W  = MUL_W + MUL_DIGIT;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [MUL_W-1:0]     r_a;
    logic [BS_W-1:0]      r_b;
    logic [PROD_W-1:0]    r_acc;
    logic [MUL_DIGIT-1:0] dig;
    logic [PP_W-1:0]      pp;

    // MSB digit first: acc = acc * radix + a * digit
    assign dig = r_b[BS_W-1 -: MUL_DIGIT];
    assign pp  = {{MUL_DIGIT{1'b0}}, r_a} * {{MUL_W{1'b0}}, dig};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NDIG);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BS_W'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << MUL_DIGIT) + PROD_W'(pp);
            r_b   <= r_b << MUL_DIGIT;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ rtl/rvb_div.sv @@
`default_nettype none

module rvb_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rvb_pkg::DIV_NW-1:0] i_num,
    input  wire logic [rvb_pkg::DIV_DW-1:0] i_den,
    output logic                            o_done,
    output logic [rvb_pkg::DIV_NW-1:0]      o_quot
);

    import rvb_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_sub;
    logic              ge;

    // restoring division, dividend bits shift out of r_q as quotient bits shift in
    assign rem_sh  = {r_rem, r_q[DIV_NW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            r_q   <= {r_q[DIV_NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

@@ rtl/rvb_sqrt.sv @@
`default_nettype none

module rvb_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rvb_pkg::SQRT_W-1:0] i_val,
    output logic                            o_done,
    output logic [rvb_pkg::SQRT_W/2-1:0]    o_root
);

    import rvb_pkg::*;

    localparam int STEPS = SQRT_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQRT_W-1:0] r_x;
    logic [SQRT_W-1:0] r_res;
    logic [SQRT_W-1:0] r_bit;
    logic [SQRT_W:0]   trial;
    logic              take;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign take  = {1'b0, r_x} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_val;
            r_res <= '0;
            r_bit <= {2'b01, {(SQRT_W-2){1'b0}}};
        end else if (r_busy) begin
            if (take) begin
                r_x   <= r_x - trial[SQRT_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[STEPS-1:0];

endmodule

`default_nettype wire

@@ rtl/rolling_volatility_band_detector.sv @@
`default_nettype none

// Channel   Handshake                      Payload
// -------   ----------------------------   ------------------------------------------
// in        i_in_valid / o_in_ready        i_price, i_stamp
// out       o_out_valid / i_out_ready      o_price_used, o_band_low, o_band_high,
//                                          o_signal, o_stamp_out
// cfg       i_cfg_we (no handshake back)   i_cfg_idx, i_cfg_data
//
// One request at a time; ready returns only once the result is written back. Most of
// the work is the two log2 chains (24 squarings each) and the exp2 product on the
// 4-bit-per-cycle multiplier; the divisions run on the 1-bit divider, the root on
// the serial square-root unit.
// Reset is synchronous, active low; the window rings need no clearing pass,
// so a request is taken in the first cycle after reset.
// A finished result waits in the output register while the next request is
// accepted; only the final write-back stalls on a full output register.

module rolling_volatility_band_detector #(
    parameter int WIN_MAX = rvb_pkg::WIN_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input requests
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [rvb_pkg::PRICE_W-1:0]    i_price,
    input  wire logic [rvb_pkg::STAMP_W-1:0]    i_stamp,
    // results
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rvb_pkg::PRICE_W-1:0]         o_price_used,
    output logic [rvb_pkg::PRICE_W-1:0]         o_band_low,
    output logic [rvb_pkg::PRICE_W-1:0]         o_band_high,
    output logic signed [1:0]                   o_signal,
    output logic [rvb_pkg::STAMP_W-1:0]         o_stamp_out,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [rvb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rvb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import rvb_pkg::*;

    localparam int AW    = $clog2(WIN_MAX);
    localparam int CW    = $clog2(WIN_MAX + 1);
    localparam int CMP_W = (CW > CFG_WIN_W) ? CW : CFG_WIN_W;
    localparam int SUM_W = PRICE_W + CW;
    localparam int SQ_W  = SQ_VAL_W + CW;
    localparam int IDX_W = $clog2(FRAC_BITS + 2);
    localparam int ITR_W = $clog2(FRAC_BITS);
    localparam int V_W   = PRICE_W + 1;

    // ---------------- configuration ----------------
    logic [CFG_WIN_W-1:0]  r_mean_win;
    logic [CFG_WIN_W-1:0]  r_rms_win;
    logic [CFG_MULT_W-1:0] r_band_mult;
    logic                  r_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_win  <= CFG_WIN_W'(MIN_WIN);
            r_rms_win   <= CFG_WIN_W'(MIN_WIN);
            r_band_mult <= CFG_MULT_W'(256);
            r_invert    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEAN_WIN: r_mean_win  <= i_cfg_data[CFG_WIN_W-1:0];
                CFG_RMS_WIN:  r_rms_win   <= i_cfg_data[CFG_WIN_W-1:0];
                CFG_MULT:     r_band_mult <= i_cfg_data[CFG_MULT_W-1:0];
                CFG_INVERT:   r_invert    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // window lengths clamped to [MIN_WIN, WIN_MAX]
    logic [CMP_W-1:0] mw_ext, rw_ext;
    logic [CW-1:0]    w_mean, w_rms;

    always_comb begin
        mw_ext = CMP_W'(r_mean_win);
        rw_ext = CMP_W'(r_rms_win);
        if (mw_ext < CMP_W'(MIN_WIN))      w_mean = CW'(MIN_WIN);
        else if (mw_ext > CMP_W'(WIN_MAX)) w_mean = CW'(WIN_MAX);
        else                               w_mean = mw_ext[CW-1:0];
        if (rw_ext < CMP_W'(MIN_WIN))      w_rms = CW'(MIN_WIN);
        else if (rw_ext > CMP_W'(WIN_MAX)) w_rms = CW'(WIN_MAX);
        else                               w_rms = rw_ext[CW-1:0];
    end

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic [PRICE_W-1:0]  r_raw;
    logic [STAMP_W-1:0]  r_stamp;
    logic [PRICE_W-1:0]  r_p;
    logic [SUM_W-1:0]    r_psum;
    logic [SQ_W-1:0]     r_ssum;
    logic [CW-1:0]       r_pcount, r_dcount;
    logic [AW-1:0]       r_phead, r_dhead;
    logic [V_W-1:0]      r_dev_abs;
    logic [SQ_VAL_W-1:0] r_sq;
    logic [V_W-1:0]      r_norm;
    logic [LG_INT_W-1:0] r_msb;
    logic [PRICE_W-1:0]  r_m;
    logic [FRAC_BITS-1:0] r_frac;
    logic [ITR_W-1:0]    r_iter;
    logic                r_lg_den;
    logic [LG_W-1:0]     r_lnum;
    logic [K_W-1:0]      r_k;
    logic [FRAC_BITS-1:0] r_f;
    logic [PRICE_W-1:0]  r_r;
    logic [IDX_W-1:0]    r_idx;
    logic [PRICE_W-1:0]  r_hi, r_lo;
    logic [PRICE_W-1:0]  r_anchor;
    logic                r_started;

    logic                r_out_valid;
    logic [PRICE_W-1:0]  r_out_p, r_out_lo, r_out_hi;
    logic [1:0]          r_out_sig;
    logic [STAMP_W-1:0]  r_out_stamp;

    // ---------------- serial units, multiplier and divider shared ----------------
    logic                mul_start, mul_done;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic                div_start, div_done;
    logic [DIV_NW-1:0]   div_num, div_quot;
    logic [DIV_DW-1:0]   div_den;
    logic                sqrt_start, sqrt_done;
    logic [SQRT_W-1:0]   sqrt_val;
    logic [SQRT_W/2-1:0] sqrt_root;

    rvb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    rvb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    rvb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (sqrt_val),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // ---------------- window rings ----------------
    // Price ring holds converted prices; the second ring holds each deviation
    // already squared, so an evicted entry needs no second multiply.
    logic [CW:0]         p_old_sum, d_old_sum;
    logic [AW-1:0]       p_old_idx, d_old_idx;
    logic [PRICE_W-1:0]  p_rdata;
    logic [SQ_VAL_W-1:0] d_rdata;
    logic                p_we, d_we;
    logic                p_evict, d_evict;
    logic [AW-1:0]       p_head_nx, d_head_nx;

    // oldest entry sits count places behind head
    always_comb begin
        p_old_sum = (CW+1)'(r_phead) + (CW+1)'(WIN_MAX) - (CW+1)'(r_pcount);
        d_old_sum = (CW+1)'(r_dhead) + (CW+1)'(WIN_MAX) - (CW+1)'(r_dcount);
        p_old_idx = (p_old_sum >= (CW+1)'(WIN_MAX)) ?
                    AW'(p_old_sum - (CW+1)'(WIN_MAX)) : AW'(p_old_sum);
        d_old_idx = (d_old_sum >= (CW+1)'(WIN_MAX)) ?
                    AW'(d_old_sum - (CW+1)'(WIN_MAX)) : AW'(d_old_sum);
        p_head_nx = (r_phead == AW'(WIN_MAX - 1)) ? '0 : r_phead + 1'b1;
        d_head_nx = (r_dhead == AW'(WIN_MAX - 1)) ? '0 : r_dhead + 1'b1;
    end

    assign p_evict = r_pcount >= w_mean;
    assign d_evict = r_dcount >= w_rms;
    assign p_we    = (r_state == S_PWIN);
    assign d_we    = (r_state == S_DWIN);

    // read addresses follow head/count, which settle long before use
    rvb_ram #(.WIDTH(PRICE_W), .DEPTH(WIN_MAX)) u_price_ring (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_phead),
        .i_wdata (r_p),
        .i_raddr (p_old_idx),
        .o_rdata (p_rdata)
    );

    rvb_ram #(.WIDTH(SQ_VAL_W), .DEPTH(WIN_MAX)) u_sq_ring (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_dhead),
        .i_wdata (r_sq),
        .i_raddr (d_old_idx),
        .o_rdata (d_rdata)
    );

    // ---------------- datapath helpers ----------------
    logic [V_W-1:0]       dev;
    logic [V_W-1:0]       dev_abs;
    logic [V_W-1:0]       sq_t;
    logic [LG_W-1:0]      lg_now;
    logic [LG_W-1:0]      l_diff;
    logic                 exp_live;
    logic [IDX_W-1:0]     f_pos;
    logic                 exp_bit;
    logic [V_W-1:0]       hi_raw;
    logic [V_W-1:0]       hi_lim;
    logic                 k_big;
    logic [PRICE_W-1:0]   hi_sat;
    logic [PRICE_W-1:0]   lo_val;
    logic [1:0]           sig;

    always_comb begin
        // deviation = p - mean, two's complement
        dev     = {1'b0, r_p} - {1'b0, div_quot[PRICE_W-1:0]};
        dev_abs = dev[V_W-1] ? (~dev + 1'b1) : dev;

        // m*m / 2^31
        sq_t = mul_prod[2*PRICE_W-1:PRICE_W-1];

        lg_now = {r_msb, r_frac};
        l_diff = (r_lnum > lg_now) ? (r_lnum - lg_now) : '0;

        exp_live = r_idx <= IDX_W'(FRAC_BITS);
        f_pos    = IDX_W'(FRAC_BITS) - r_idx;
        exp_bit  = exp_live && r_f[f_pos[$clog2(FRAC_BITS)-1:0]];

        // upper edge: anchor * 2^f, then times 2^k with saturation
        hi_raw = mul_prod[2*PRICE_W-1:PRICE_W-1];
        hi_lim = {1'b0, {PRICE_W{1'b1}}} >> r_k[4:0];
        k_big  = |r_k[K_W-1:5];
        if (hi_raw == '0)                     hi_sat = '0;
        else if (k_big || (hi_raw > hi_lim))  hi_sat = {PRICE_W{1'b1}};
        else                                  hi_sat = hi_raw[PRICE_W-1:0] << r_k[4:0];

        // lower edge: anchor / 2^f, then divided by 2^k
        lo_val = k_big ? '0 : (div_quot[PRICE_W-1:0] >> r_k[4:0]);

        if (r_p > r_hi)      sig = SIG_ABOVE;
        else if (r_p < r_lo) sig = SIG_BELOW;
        else                 sig = SIG_NONE;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sqrt_start = (r_state == S_MS_W) && div_done;
        sqrt_val   = {div_quot[SQ_VAL_W-1:0], 16'h0000};

        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_CONV;
            S_CONV: begin
                if (r_invert && (r_raw > PRICE_W'(1))) begin
                    div_start = 1'b1;
                    div_num   = DIV_NW'(1) << PRICE_W;
                    div_den   = DIV_DW'(r_raw);
                    n_state   = S_CONV_W;
                end else begin
                    n_state = S_PWIN;
                end
            end
            S_CONV_W: if (div_done) n_state = S_PWIN;
            S_PWIN:   n_state = S_MEAN;
            S_MEAN: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_psum);
                div_den   = DIV_DW'(r_pcount);
                n_state   = S_MEAN_W;
            end
            S_MEAN_W: if (div_done) n_state = S_SQ;
            S_SQ: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(r_dev_abs);
                mul_b     = MUL_W'(r_dev_abs);
                n_state   = S_SQ_W;
            end
            S_SQ_W:   if (mul_done) n_state = S_DWIN;
            S_DWIN:   n_state = S_MS;
            S_MS: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_ssum);
                div_den   = DIV_DW'(r_dcount);
                n_state   = S_MS_W;
            end
            S_MS_W:   if (div_done) n_state = S_RMS_W;
            S_RMS_W:  if (sqrt_done) n_state = S_LG_NORM;
            S_LG_NORM: if (r_norm[V_W-1]) n_state = S_LG_SQ;
            S_LG_SQ: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(r_m);
                mul_b     = MUL_W'(r_m);
                n_state   = S_LG_SQW;
            end
            S_LG_SQW: begin
                if (mul_done) begin
                    n_state = (r_iter == ITR_W'(FRAC_BITS - 1)) ? S_LG_END : S_LG_SQ;
                end
            end
            S_LG_END: n_state = r_lg_den ? S_EMUL : S_LG_NORM;
            S_EMUL: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(l_diff);
                mul_b     = MUL_W'(r_band_mult);
                n_state   = S_EMUL_W;
            end
            S_EMUL_W: if (mul_done) n_state = S_EXP;
            S_EXP: begin
                if (!exp_live) begin
                    n_state = S_HI;
                end else if (exp_bit) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(r_r);
                    mul_b     = MUL_W'(EXP_COEF[r_idx]);
                    n_state   = S_EXP_W;
                end
            end
            S_EXP_W:  if (mul_done) n_state = S_EXP;
            S_HI: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(r_anchor);
                mul_b     = MUL_W'(r_r);
                n_state   = S_HI_W;
            end
            S_HI_W:   if (mul_done) n_state = S_LO;
            S_LO: begin
                div_start = 1'b1;
                div_num   = {1'b0, r_anchor, {(PRICE_W-1){1'b0}}};
                div_den   = DIV_DW'(r_r);
                n_state   = S_LO_W;
            end
            S_LO_W:   if (div_done) n_state = S_OUT;
            S_OUT:    if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- window and item control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum    <= '0;
            r_ssum    <= '0;
            r_pcount  <= '0;
            r_dcount  <= '0;
            r_phead   <= '0;
            r_dhead   <= '0;
            r_anchor  <= '0;
            r_started <= 1'b0;
        end else begin
            unique case (r_state)
                S_PWIN: begin
                    r_psum   <= r_psum - (p_evict ? SUM_W'(p_rdata) : '0) + SUM_W'(r_p);
                    r_pcount <= p_evict ? r_pcount : r_pcount + 1'b1;
                    r_phead  <= p_head_nx;
                end
                S_DWIN: begin
                    r_ssum   <= r_ssum - (d_evict ? SQ_W'(d_rdata) : '0) + SQ_W'(r_sq);
                    r_dcount <= d_evict ? r_dcount : r_dcount + 1'b1;
                    r_dhead  <= d_head_nx;
                end
                S_EMUL: begin
                    // first sample seeds the anchor before the band is built
                    if (!r_started) begin
                        r_anchor  <= r_p;
                        r_started <= 1'b1;
                    end
                end
                S_OUT: begin
                    if ((!r_out_valid || i_out_ready) && (sig != SIG_NONE)) begin
                        r_anchor <= r_p;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- arithmetic working registers ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_raw   <= i_price;
                    r_stamp <= i_stamp;
                end
            end
            S_CONV: begin
                if (r_invert) r_p <= {PRICE_W{1'b1}};   // zero or one saturate
                else          r_p <= (r_raw == '0) ? PRICE_W'(1) : r_raw;
            end
            S_CONV_W:  if (div_done) r_p <= div_quot[PRICE_W-1:0];
            S_MEAN_W:  if (div_done) r_dev_abs <= dev_abs;
            S_SQ_W:    if (mul_done) r_sq <= mul_prod[SQ_VAL_W+15:16];
            S_RMS_W: begin
                if (sqrt_done) begin
                    r_norm   <= V_W'(sqrt_root) + V_W'(r_p);
                    r_msb    <= LG_INT_W'(V_W - 1);
                    r_lg_den <= 1'b0;
                end
            end
            S_LG_NORM: begin
                // walk the leading one up to the top bit
                if (r_norm[V_W-1]) begin
                    r_m    <= r_norm[V_W-1:1];
                    r_frac <= '0;
                    r_iter <= '0;
                end else begin
                    r_norm <= r_norm << 1;
                    r_msb  <= r_msb - 1'b1;
                end
            end
            S_LG_SQW: begin
                if (mul_done) begin
                    r_frac <= {r_frac[FRAC_BITS-2:0], sq_t[V_W-1]};
                    r_m    <= sq_t[V_W-1] ? sq_t[V_W-1:1] : sq_t[PRICE_W-1:0];
                    r_iter <= r_iter + 1'b1;
                end
            end
            S_LG_END: begin
                if (!r_lg_den) begin
                    r_lnum   <= lg_now;
                    r_norm   <= {1'b0, r_p};
                    r_msb    <= LG_INT_W'(V_W - 1);
                    r_lg_den <= 1'b1;
                end
            end
            S_EMUL_W: begin
                if (mul_done) begin
                    r_k   <= mul_prod[K_W+FRAC_BITS+7:FRAC_BITS+8];
                    r_f   <= mul_prod[FRAC_BITS+7:8];
                    r_r   <= {1'b1, {(PRICE_W-1){1'b0}}};
                    r_idx <= IDX_W'(1);
                end
            end
            S_EXP:     if (exp_live && !exp_bit) r_idx <= r_idx + 1'b1;
            S_EXP_W: begin
                if (mul_done) begin
                    r_r   <= mul_prod[2*PRICE_W-2:PRICE_W-1];
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_HI_W:    if (mul_done) r_hi <= hi_sat;
            S_LO_W:    if (div_done) r_lo <= lo_val;
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out_p     <= r_p;
            r_out_lo    <= r_lo;
            r_out_hi    <= r_hi;
            r_out_sig   <= sig;
            r_out_stamp <= r_stamp;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_price_used = r_out_p;
    assign o_band_low   = r_out_lo;
    assign o_band_high  = r_out_hi;
    assign o_signal     = r_out_sig;
    assign o_stamp_out  = r_out_stamp;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcount <= CW'(WIN_MAX)) && (r_dcount <= CW'(WIN_MAX)))
        else $error("window count beyond ring depth");

    a_band_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lo <= r_out_hi))
        else $error("lower band edge above upper edge");

    a_sig_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_sig == SIG_ABOVE)) |-> (r_out_p > r_out_hi))
        else $error("breakout up without price above band");

    a_one_at_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while one is in flight");

endmodule

`default_nettype wire
